FILE: rtl/rdc_pkg.sv
// ----------------------------------------------------------------------------
// rdc_pkg: shared definitions for the reverse delay crossfade
// Store geometry, register widths, register index codes and the request
// structure that carries one access cycle to the sample store.
// ----------------------------------------------------------------------------
package rdc_pkg;

  // store geometry and sample width
  localparam int unsigned STORE_DEPTH = 131072;
  localparam int unsigned SAMPLE_BITS = 24;
  localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);

  // register widths
  localparam int unsigned LEN_W      = 17;
  localparam int unsigned FADE_LEN_W = 14;
  localparam int unsigned STEP_W     = 17;
  localparam int unsigned CFG_DATA_W = 17;
  localparam int unsigned CFG_IDX_W  = 2;

  // Q1.16 weight, one is 2^16
  localparam int unsigned WEIGHT_W = 17;
  localparam logic [WEIGHT_W-1:0] Q_ONE = WEIGHT_W'(65536);

  // register reset values
  localparam logic [LEN_W-1:0]      DELAY_LENGTH_RST = LEN_W'(47760);
  localparam logic [FADE_LEN_W-1:0] FADE_LENGTH_RST  = FADE_LEN_W'(9600);
  localparam logic [STEP_W-1:0]     FADE_STEP_RST    = STEP_W'(7);

  // product of a weight (with sign bit) and a sample
  localparam int unsigned PROD_W = WEIGHT_W + 1 + SAMPLE_BITS;

  // register index codes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DELAY_LENGTH = 2'd0,
    CFG_FADE_LENGTH  = 2'd1,
    CFG_FADE_STEP    = 2'd2
  } cfg_idx_e;

  // one access cycle of the sample store: two reads and one write
  typedef struct packed {
    logic                          rd_en;
    logic [ADDR_W-1:0]             rd_addr_a;
    logic [ADDR_W-1:0]             rd_addr_b;
    logic                          wr_en;
    logic [ADDR_W-1:0]             wr_addr;
    logic signed [SAMPLE_BITS-1:0] wr_data;
  } store_req_t;

endpackage

FILE: rtl/rdc_store.sv
// ----------------------------------------------------------------------------
// rdc_store: circular sample store
// Synchronous memory with one write port and two read ports. Reads return
// the contents from before a write to the same address in the same cycle,
// and the read data registers hold while no read is issued.
// ----------------------------------------------------------------------------
module rdc_store import rdc_pkg::*; (
  input  logic                          clk_i,
  input  store_req_t                    req_i,
  output logic signed [SAMPLE_BITS-1:0] rd_data_a_o,
  output logic signed [SAMPLE_BITS-1:0] rd_data_b_o
);

  logic signed [SAMPLE_BITS-1:0] mem [STORE_DEPTH];
  logic signed [SAMPLE_BITS-1:0] rd_data_a_q;
  logic signed [SAMPLE_BITS-1:0] rd_data_b_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
  end

  // read ports, read-first
  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_data_a_q <= mem[req_i.rd_addr_a];
      rd_data_b_q <= mem[req_i.rd_addr_b];
    end
  end

  assign rd_data_a_o = rd_data_a_q;
  assign rd_data_b_o = rd_data_b_q;

endmodule

FILE: rtl/reverse_delay_crossfade_top.sv
// ----------------------------------------------------------------------------
// reverse_delay_crossfade_top: reverse delay with two-segment crossfade
// Writes each sample into a circular store, plays two backward segments
// and crossfades between them; output is dry plus half the reverse mix.
// ----------------------------------------------------------------------------
// The block takes one sample per clock cycle as long as the output side is
// not stalled. That rate comes from the sample store, which serves both
// segment reads and the write of the new sample in the same cycle (two read
// ports, one write port, read-first). The segment and fade state is updated
// in the accept cycle; the store read, the two weight multiplies and the
// final sum with saturation each take one pipeline stage. The store is not
// cleared after reset: a fill flag marks whether the write pointer has gone
// all the way round, and entries not yet written read as zero, so samples
// are accepted right after reset. The user must write registers only while
// idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module reverse_delay_crossfade_top import rdc_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]         cfg_data_i,
  // input samples
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_in_i,
  // output samples
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [SAMPLE_BITS-1:0] sample_out_o
);

  localparam int unsigned SUM_W = SAMPLE_BITS + 2;
  localparam int unsigned MIX_W = PROD_W + 1;

  // configuration registers
  logic [LEN_W-1:0]      delay_len_q;
  logic [FADE_LEN_W-1:0] fade_len_q;
  logic [STEP_W-1:0]     fade_step_q;

  // segment and fade state
  logic [ADDR_W-1:0]     wr_idx_q, wr_idx_d;
  logic                  wrapped_q, wrapped_d;
  logic [ADDR_W-1:0]     a_head_q, a_head_d, b_head_q, b_head_d;
  logic [LEN_W-1:0]      a_played_q, a_played_d, b_played_q, b_played_d;
  logic [LEN_W-1:0]      a_len_q, a_len_d, b_len_q, b_len_d;
  logic                  a_act_q, a_act_d, b_act_q, b_act_d;
  logic                  a_lag_q, a_lag_d;
  logic                  first_q, first_d;
  logic                  run_q, run_d;
  logic [FADE_LEN_W-1:0] cnt_q, cnt_d;
  logic                  falling_q, falling_d;
  logic [WEIGHT_W-1:0]   weight_q, weight_d;
  logic [WEIGHT_W-1:0]   mix_pos_q, mix_pos_d;
  logic [STEP_W:0]       weight_sum;
  logic                  ok_a, ok_b;

  // pipeline
  logic                          ready1, ready2, ready3, in_accept;
  logic                          v1_q, v2_q, v3_q;
  logic signed [SAMPLE_BITS-1:0] s1_x_q, s2_x_q;
  logic [WEIGHT_W-1:0]           s1_mp_q;
  logic                          s1_ok_a_q, s1_ok_b_q;
  logic signed [PROD_W-1:0]      s2_pa_q, s2_pb_q;
  logic signed [SAMPLE_BITS-1:0] out_q;

  store_req_t                    req;
  logic signed [SAMPLE_BITS-1:0] rd_a, rd_b;

  // stage 2 operands
  logic [WEIGHT_W-1:0]           w_a;
  logic signed [SAMPLE_BITS-1:0] y_a, y_b;

  // stage 3 sum and saturation
  logic signed [MIX_W-1:0]       mix;
  logic signed [MIX_W-1:0]       mix_sh;
  logic signed [SUM_W-1:0]       sum;
  logic signed [SAMPLE_BITS-1:0] sat;

  // handshake: each stage moves when the next is empty or moving
  assign ready3     = !v3_q || !out_stall_i;
  assign ready2     = !v2_q || ready3;
  assign ready1     = !v1_q || ready2;
  assign in_accept  = in_valid_i && ready1;
  assign in_stall_o = !ready1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_len_q <= DELAY_LENGTH_RST;
      fade_len_q  <= FADE_LENGTH_RST;
      fade_step_q <= FADE_STEP_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DELAY_LENGTH: delay_len_q <= cfg_data_i[LEN_W-1:0];
        CFG_FADE_LENGTH:  fade_len_q  <= cfg_data_i[FADE_LEN_W-1:0];
        CFG_FADE_STEP:    fade_step_q <= cfg_data_i[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // segment, fade and store access for the accepted sample
  always_comb begin
    wr_idx_d   = wr_idx_q;
    wrapped_d  = wrapped_q;
    a_head_d   = a_head_q;
    a_played_d = a_played_q;
    a_len_d    = a_len_q;
    a_act_d    = a_act_q;
    b_head_d   = b_head_q;
    b_played_d = b_played_q;
    b_len_d    = b_len_q;
    b_act_d    = b_act_q;
    a_lag_d    = a_lag_q;
    first_d    = first_q;
    run_d      = run_q;
    cnt_d      = cnt_q;
    falling_d  = falling_q;
    weight_d   = weight_q;
    mix_pos_d  = mix_pos_q;
    weight_sum = '0;
    ok_a       = 1'b0;
    ok_b       = 1'b0;
    req        = '0;
    if (in_accept) begin
      // first sample after reset starts segment a
      if (first_q) begin
        b_head_d   = '0;
        b_played_d = '0;
        b_len_d    = '0;
        b_act_d    = 1'b0;
        a_head_d   = wr_idx_q;
        a_played_d = '0;
        a_len_d    = delay_len_q;
        a_act_d    = 1'b1;
        a_lag_d    = !a_lag_d;
        first_d    = 1'b0;
      end

      // segment reads, unwritten entries read as zero
      req.rd_en     = 1'b1;
      req.rd_addr_a = a_head_d;
      req.rd_addr_b = b_head_d;
      ok_a = a_act_d && (wrapped_q || (a_head_d < wr_idx_q));
      ok_b = b_act_d && (wrapped_q || (b_head_d < wr_idx_q));
      if (a_act_d) begin
        a_head_d   = (a_head_d == '0) ? ADDR_W'(STORE_DEPTH - 1) : a_head_d - 1'b1;
        a_played_d = a_played_d + 1'b1;
      end
      if (b_act_d) begin
        b_head_d   = (b_head_d == '0) ? ADDR_W'(STORE_DEPTH - 1) : b_head_d - 1'b1;
        b_played_d = b_played_d + 1'b1;
      end

      // crossfade ramp
      if (run_q) begin
        mix_pos_d = weight_q;
        if (cnt_q < fade_len_q) begin
          if (!falling_q) begin
            weight_sum = {1'b0, weight_q} + {1'b0, fade_step_q};
            weight_d   = (weight_sum > {1'b0, Q_ONE}) ? Q_ONE : weight_sum[WEIGHT_W-1:0];
          end else begin
            weight_d = (weight_q < fade_step_q) ? '0 : weight_q - fade_step_q;
          end
          cnt_d = cnt_q + 1'b1;
        end else begin
          run_d     = 1'b0;
          cnt_d     = '0;
          falling_d = !falling_q;
        end
      end

      // store the new sample
      req.wr_en   = 1'b1;
      req.wr_addr = wr_idx_q;
      req.wr_data = sample_in_i;

      // restart the lagging segment when the leader nears its end
      if (a_lag_d) begin
        if (!run_d && (({1'b0, b_played_d} + (LEN_W+1)'(fade_len_q)) >= {1'b0, b_len_d}))
        begin
          run_d      = 1'b1;
          weight_d   = Q_ONE;
          a_head_d   = wr_idx_q;
          a_played_d = '0;
          a_len_d    = delay_len_q;
          a_act_d    = 1'b1;
          a_lag_d    = !a_lag_d;
        end
      end else begin
        if (!run_d && (({1'b0, a_played_d} + (LEN_W+1)'(fade_len_q)) >= {1'b0, a_len_d}))
        begin
          run_d      = 1'b1;
          weight_d   = '0;
          b_head_d   = wr_idx_q;
          b_played_d = '0;
          b_len_d    = delay_len_q;
          b_act_d    = 1'b1;
          a_lag_d    = !a_lag_d;
        end
      end

      // stop segments that have played out
      if (a_played_d >= a_len_d) begin
        a_head_d   = '0;
        a_played_d = '0;
        a_len_d    = '0;
        a_act_d    = 1'b0;
      end
      if (b_played_d >= b_len_d) begin
        b_head_d   = '0;
        b_played_d = '0;
        b_len_d    = '0;
        b_act_d    = 1'b0;
      end

      // advance the write pointer
      if (wr_idx_q == ADDR_W'(STORE_DEPTH - 1)) begin
        wr_idx_d  = '0;
        wrapped_d = 1'b1;
      end else begin
        wr_idx_d = wr_idx_q + 1'b1;
      end
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_idx_q   <= '0;
      wrapped_q  <= 1'b0;
      a_head_q   <= '0;
      a_played_q <= '0;
      a_len_q    <= '0;
      a_act_q    <= 1'b0;
      b_head_q   <= '0;
      b_played_q <= '0;
      b_len_q    <= '0;
      b_act_q    <= 1'b0;
      a_lag_q    <= 1'b1;
      first_q    <= 1'b1;
      run_q      <= 1'b0;
      cnt_q      <= '0;
      falling_q  <= 1'b0;
      weight_q   <= '0;
      mix_pos_q  <= '0;
    end else begin
      wr_idx_q   <= wr_idx_d;
      wrapped_q  <= wrapped_d;
      a_head_q   <= a_head_d;
      a_played_q <= a_played_d;
      a_len_q    <= a_len_d;
      a_act_q    <= a_act_d;
      b_head_q   <= b_head_d;
      b_played_q <= b_played_d;
      b_len_q    <= b_len_d;
      b_act_q    <= b_act_d;
      a_lag_q    <= a_lag_d;
      first_q    <= first_d;
      run_q      <= run_d;
      cnt_q      <= cnt_d;
      falling_q  <= falling_d;
      weight_q   <= weight_d;
      mix_pos_q  <= mix_pos_d;
    end
  end

  // sample store
  rdc_store u_store (
    .clk_i       (clk_i),
    .req_i       (req),
    .rd_data_a_o (rd_a),
    .rd_data_b_o (rd_b)
  );

  // pipeline valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (ready1) v1_q <= in_accept;
      if (ready2) v2_q <= v1_q;
      if (ready3) v3_q <= v2_q;
    end
  end

  // stage 1: side data alongside the store read
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_x_q    <= sample_in_i;
      s1_mp_q   <= mix_pos_d;
      s1_ok_a_q <= ok_a;
      s1_ok_b_q <= ok_b;
    end
  end

  // stage 2: weight both segment samples
  assign w_a = Q_ONE - s1_mp_q;
  assign y_a = s1_ok_a_q ? rd_a : '0;
  assign y_b = s1_ok_b_q ? rd_b : '0;

  always_ff @(posedge clk_i) begin
    if (v1_q && ready2) begin
      s2_x_q  <= s1_x_q;
      s2_pa_q <= $signed({1'b0, w_a}) * y_a;
      s2_pb_q <= $signed({1'b0, s1_mp_q}) * y_b;
    end
  end

  // stage 3: half the mix plus dry, saturated
  assign mix    = {s2_pa_q[PROD_W-1], s2_pa_q} + {s2_pb_q[PROD_W-1], s2_pb_q};
  assign mix_sh = mix >>> 17;
  assign sum    = {{2{s2_x_q[SAMPLE_BITS-1]}}, s2_x_q} + mix_sh[SUM_W-1:0];

  always_comb begin
    sat = sum[SAMPLE_BITS-1:0];
    if (!sum[SUM_W-1] && (sum[SUM_W-2:SAMPLE_BITS-1] != '0)) begin
      sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end else if (sum[SUM_W-1] && (sum[SUM_W-2:SAMPLE_BITS-1] != '1)) begin
      sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (v2_q && ready3) begin
      out_q <= sat;
    end
  end

  assign out_valid_o  = v3_q;
  assign sample_out_o = out_q;

  // an accepted transaction always enters the store stage
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> v1_q)
    else $error("accepted transaction did not enter the pipeline");

  // a full pipeline behind a stalled output must stall the input
  a_full_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && v2_q && v3_q && out_stall_i) |-> in_stall_o)
    else $error("input not stalled with full pipeline");

  // fade weights stay within zero to one
  a_weight_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (weight_q <= Q_ONE) && (mix_pos_q <= Q_ONE))
    else $error("fade weight out of range");

  // the write pointer wrapping marks the store as filled
  a_wrap_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && (wr_idx_q == ADDR_W'(STORE_DEPTH - 1))) |=> (wrapped_q && (wr_idx_q == '0)))
    else $error("store fill flag not set on wrap");

  // a segment that is idle has its head parked at zero
  a_idle_parked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!a_act_q |-> (a_head_q == '0)) and (!b_act_q |-> (b_head_q == '0)))
    else $error("inactive segment head not cleared");

endmodule
